FILE: design/kvsm_pkg.sv
// Shared constants for the key velocity state machine core.
package kvsm_pkg;

   localparam int KEY_W    = 6;
   localparam int OP_W     = 2;
   localparam int TIME_W   = 32;
   localparam int VEL_W    = 7;
   localparam int NOTE_W   = 7;
   localparam int PHASE_W  = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam int NUM_KEYS_DEFAULT = 64;

   // contact events
   localparam logic [OP_W-1:0] OP_HALF_PRESSED  = 2'd0;
   localparam logic [OP_W-1:0] OP_FULL_PRESSED  = 2'd1;
   localparam logic [OP_W-1:0] OP_HALF_RELEASED = 2'd2;
   localparam logic [OP_W-1:0] OP_FULL_RELEASED = 2'd3;

   // per-key phases
   localparam logic [PHASE_W-1:0] PH_IDLE           = 2'd0;
   localparam logic [PHASE_W-1:0] PH_HALF_PRESSING  = 2'd1;
   localparam logic [PHASE_W-1:0] PH_FULL           = 2'd2;
   localparam logic [PHASE_W-1:0] PH_HALF_RELEASING = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_VELOCITY    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_VELOCITY    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FASTEST_TIME_US = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOWEST_TIME_US = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LOWEST_NOTE     = 3'd4;

   // register reset values
   localparam logic [VEL_W-1:0]  MIN_VELOCITY_RST    = 7'd30;
   localparam logic [VEL_W-1:0]  MAX_VELOCITY_RST    = 7'd127;
   localparam logic [TIME_W-1:0] FASTEST_TIME_US_RST = 32'd10000;
   localparam logic [TIME_W-1:0] SLOWEST_TIME_US_RST = 32'd40000;
   localparam logic [NOTE_W-1:0] LOWEST_NOTE_RST     = 7'd36;

endpackage

FILE: design/key_velocity_state_machine_core.sv
// Key velocity scanner: per-key two-contact state machine with iterative velocity divide.
//
// Request channel (req_*): one contact event per request, key index, contact op and a
// free-running microsecond timestamp. Taken when req_valid is high and req_stall is low.
// Response channel (rsp_*): zero or one MIDI-style note message per request. A note-on
// carries the strike velocity, a note-off carries velocity zero. Taken when rsp_valid is
// high and rsp_stall is low.
// csr_*: write-only registers (min/max velocity, fastest/slowest stroke time, lowest
// note). The user must write them only while the block is idle; this is not enforced.
// Timing: one request at a time; req_stall is high from the cycle after acceptance until
// the block is idle again. An event that emits nothing returns to idle from S_READ. A
// note-off response passes S_READ and S_OUT before it is registered. A note-on at or
// below the fastest time or at or beyond the slowest ends after the compares; any other
// runs compares, one multiply and a 7-step restoring divide on the shared subtractor.
// The block goes idle as the response is registered, so the divide path sets the worst
// case per request. The response sits in an output register; while it is stalled the
// block can still accept and work on the next request, holding only if a second result
// is ready.
// Reset (synchronous): all keys idle, registers at their defaults, no response pending.
// Stroke start times are only read after they were written, so they have no reset.
module key_velocity_state_machine_core #(
   parameter int NUM_KEYS = kvsm_pkg::NUM_KEYS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // request
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [kvsm_pkg::KEY_W-1:0]          req_key_index,
   input  logic [kvsm_pkg::OP_W-1:0]           req_op,
   input  logic [kvsm_pkg::TIME_W-1:0]         req_timestamp_us,
   // response
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_note_on,
   output logic [kvsm_pkg::NOTE_W-1:0]         rsp_note_number,
   output logic [kvsm_pkg::VEL_W-1:0]          rsp_velocity,
   // configuration
   input  logic                                csr_write,
   input  logic [kvsm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [kvsm_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int KeyAw  = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam int ProdW  = kvsm_pkg::TIME_W + kvsm_pkg::VEL_W;
   localparam int CntW   = 3;
   localparam logic [7:0] NumKeysV = 8'(NUM_KEYS);
   localparam logic [CntW-1:0] DivTop = 3'(kvsm_pkg::VEL_W - 1);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_READ = 4'd1;
   localparam logic [3:0] S_DIFF = 4'd2;
   localparam logic [3:0] S_SLOW = 4'd3;
   localparam logic [3:0] S_DEN  = 4'd4;
   localparam logic [3:0] S_MUL  = 4'd5;
   localparam logic [3:0] S_DIV  = 4'd6;
   localparam logic [3:0] S_FIN  = 4'd7;
   localparam logic [3:0] S_OUT  = 4'd8;

   // configuration registers
   logic [kvsm_pkg::VEL_W-1:0]  min_vel_ff, max_vel_ff;
   logic [kvsm_pkg::TIME_W-1:0] fast_ff, slow_ff;
   logic [kvsm_pkg::NOTE_W-1:0] low_note_ff;

   // key memories
   logic [kvsm_pkg::PHASE_W-1:0] phase_mem [NUM_KEYS];
   logic [kvsm_pkg::TIME_W-1:0]  time_mem  [NUM_KEYS];
   logic [NUM_KEYS-1:0]          key_valid_ff;

   logic [3:0]                   state_ff, state_in;
   logic [kvsm_pkg::KEY_W-1:0]   key_ff;
   logic [kvsm_pkg::OP_W-1:0]    op_ff;
   logic [kvsm_pkg::TIME_W-1:0]  ts_ff;
   logic [kvsm_pkg::PHASE_W-1:0] phase_rd_ff;
   logic                         valid_rd_ff;
   logic [kvsm_pkg::TIME_W-1:0]  time_rd_ff;

   logic [kvsm_pkg::TIME_W-1:0]  dt_ff, dt_in;
   logic [kvsm_pkg::TIME_W-1:0]  diff_ff, diff_in;
   logic [kvsm_pkg::TIME_W-1:0]  den_ff, den_in;
   logic [ProdW-1:0]             rem_ff, rem_in;
   logic [kvsm_pkg::VEL_W-1:0]   q_ff, q_in;
   logic [CntW-1:0]              cnt_ff, cnt_in;
   logic                         neg_ff, neg_in;
   logic [kvsm_pkg::VEL_W-1:0]   span_abs_ff, span_abs_in;
   logic                         res_on_ff, res_on_in;
   logic [kvsm_pkg::VEL_W-1:0]   res_vel_ff, res_vel_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_on_ff, rsp_on_in;
   logic [kvsm_pkg::NOTE_W-1:0]  rsp_note_ff, rsp_note_in;
   logic [kvsm_pkg::VEL_W-1:0]   rsp_vel_ff, rsp_vel_in;

   logic                         req_accept;
   logic [KeyAw-1:0]             req_addr, key_addr;
   logic                         key_in_range;
   logic [kvsm_pkg::PHASE_W-1:0] cur_phase, next_phase;
   logic                         phase_we, time_we;
   logic [ProdW-1:0]             alu_a, alu_b;
   logic [ProdW:0]               alu_d;
   logic                         alu_borrow;
   logic [7:0]                   span;
   logic [ProdW-1:0]             prod;
   logic                         out_free;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign req_addr   = KeyAw'(req_key_index);
   assign key_addr   = KeyAw'(key_ff);
   assign key_in_range = ({2'b00, key_ff} < NumKeysV);
   assign cur_phase  = valid_rd_ff ? phase_rd_ff : kvsm_pkg::PH_IDLE;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // shared subtractor
   assign alu_d      = {1'b0, alu_a} - {1'b0, alu_b};
   assign alu_borrow = alu_d[ProdW];

   assign span = {1'b0, max_vel_ff} - {1'b0, min_vel_ff};
   assign prod = ProdW'(diff_ff) * ProdW'(span_abs_ff);

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_note_on     = rsp_on_ff;
   assign rsp_note_number = rsp_note_ff;
   assign rsp_velocity    = rsp_vel_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         min_vel_ff  <= kvsm_pkg::MIN_VELOCITY_RST;
         max_vel_ff  <= kvsm_pkg::MAX_VELOCITY_RST;
         fast_ff     <= kvsm_pkg::FASTEST_TIME_US_RST;
         slow_ff     <= kvsm_pkg::SLOWEST_TIME_US_RST;
         low_note_ff <= kvsm_pkg::LOWEST_NOTE_RST;
      end else if (csr_write) begin
         case (csr_index)
            kvsm_pkg::CSR_MIN_VELOCITY:    min_vel_ff  <= csr_wdata[kvsm_pkg::VEL_W-1:0];
            kvsm_pkg::CSR_MAX_VELOCITY:    max_vel_ff  <= csr_wdata[kvsm_pkg::VEL_W-1:0];
            kvsm_pkg::CSR_FASTEST_TIME_US: fast_ff     <= csr_wdata;
            kvsm_pkg::CSR_SLOWEST_TIME_US: slow_ff     <= csr_wdata;
            kvsm_pkg::CSR_LOWEST_NOTE:     low_note_ff <= csr_wdata[kvsm_pkg::NOTE_W-1:0];
            default: ;
         endcase
      end
   end

   // key memories, registered read on request accept
   always_ff @(posedge clock) begin
      if (phase_we) begin
         phase_mem[key_addr] <= next_phase;
      end
      if (time_we) begin
         time_mem[key_addr] <= ts_ff;
      end
      if (req_accept) begin
         phase_rd_ff <= phase_mem[req_addr];
         time_rd_ff  <= time_mem[req_addr];
         key_ff      <= req_key_index;
         op_ff       <= req_op;
         ts_ff       <= req_timestamp_us;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_valid_ff <= '0;
         valid_rd_ff  <= 1'b0;
      end else begin
         if (phase_we) begin
            key_valid_ff[key_addr] <= 1'b1;
         end
         if (req_accept) begin
            valid_rd_ff <= key_valid_ff[req_addr];
         end
      end
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      dt_in       = dt_ff;
      diff_in     = diff_ff;
      den_in      = den_ff;
      rem_in      = rem_ff;
      q_in        = q_ff;
      cnt_in      = cnt_ff;
      neg_in      = neg_ff;
      span_abs_in = span_abs_ff;
      res_on_in   = res_on_ff;
      res_vel_in  = res_vel_ff;
      next_phase  = cur_phase;
      phase_we    = 1'b0;
      time_we     = 1'b0;
      alu_a       = '0;
      alu_b       = '0;
      rsp_valid_in = rsp_valid_ff;
      rsp_on_in    = rsp_on_ff;
      rsp_note_in  = rsp_note_ff;
      rsp_vel_in   = rsp_vel_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            alu_a    = ProdW'(ts_ff);
            alu_b    = ProdW'(time_rd_ff);
            dt_in    = alu_d[kvsm_pkg::TIME_W-1:0];
            state_in = S_IDLE;
            if (key_in_range) begin
               phase_we = 1'b1;
               case (cur_phase)
                  kvsm_pkg::PH_IDLE: begin
                     if (op_ff == kvsm_pkg::OP_HALF_PRESSED) begin
                        next_phase = kvsm_pkg::PH_HALF_PRESSING;
                        time_we    = 1'b1;
                     end
                  end
                  kvsm_pkg::PH_HALF_PRESSING: begin
                     if (op_ff == kvsm_pkg::OP_HALF_RELEASED) begin
                        next_phase = kvsm_pkg::PH_IDLE;
                     end else if (op_ff == kvsm_pkg::OP_FULL_PRESSED) begin
                        next_phase = kvsm_pkg::PH_FULL;
                        res_on_in  = 1'b1;
                        state_in   = S_DIFF;
                     end
                  end
                  kvsm_pkg::PH_FULL: begin
                     if (op_ff == kvsm_pkg::OP_FULL_RELEASED) begin
                        next_phase = kvsm_pkg::PH_HALF_RELEASING;
                        res_on_in  = 1'b0;
                        res_vel_in = '0;
                        state_in   = S_OUT;
                     end
                  end
                  default: begin
                     if (op_ff == kvsm_pkg::OP_HALF_RELEASED) begin
                        next_phase = kvsm_pkg::PH_IDLE;
                     end
                  end
               endcase
            end
         end
         S_DIFF: begin
            alu_a   = ProdW'(dt_ff);
            alu_b   = ProdW'(fast_ff);
            diff_in = alu_d[kvsm_pkg::TIME_W-1:0];
            // dt <= fastest: full velocity
            if (alu_borrow || (alu_d == '0)) begin
               res_vel_in = max_vel_ff;
               state_in   = S_OUT;
            end else begin
               state_in = S_SLOW;
            end
         end
         S_SLOW: begin
            alu_a = ProdW'(dt_ff);
            alu_b = ProdW'(slow_ff);
            if (!alu_borrow) begin
               res_vel_in = min_vel_ff;
               state_in   = S_OUT;
            end else begin
               state_in = S_DEN;
            end
         end
         S_DEN: begin
            alu_a    = ProdW'(slow_ff);
            alu_b    = ProdW'(fast_ff);
            den_in   = alu_d[kvsm_pkg::TIME_W-1:0];
            neg_in   = span[7];
            span_abs_in = span[7] ? 7'(-span) : span[kvsm_pkg::VEL_W-1:0];
            state_in = S_MUL;
         end
         S_MUL: begin
            rem_in   = prod;
            q_in     = '0;
            cnt_in   = DivTop;
            state_in = S_DIV;
         end
         S_DIV: begin
            // quotient is below 128 since dt - fastest < slowest - fastest
            alu_a = rem_ff;
            alu_b = ProdW'(den_ff) << cnt_ff;
            if (!alu_borrow) begin
               rem_in       = alu_d[ProdW-1:0];
               q_in[cnt_ff] = 1'b1;
            end
            if (cnt_ff == '0) begin
               state_in = S_FIN;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_FIN: begin
            // floor of the velocity: round magnitude up for a positive span, down for a negative one
            if (neg_ff) begin
               res_vel_in = max_vel_ff + q_ff;
            end else begin
               res_vel_in = max_vel_ff - q_ff - 7'(rem_ff != '0);
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_on_in    = res_on_ff;
               rsp_note_in  = low_note_ff + {1'b0, key_ff};
               rsp_vel_in   = res_vel_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dt_ff       <= dt_in;
      diff_ff     <= diff_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      q_ff        <= q_in;
      cnt_ff      <= cnt_in;
      neg_ff      <= neg_in;
      span_abs_ff <= span_abs_in;
      res_on_ff   <= res_on_in;
      res_vel_ff  <= res_vel_in;
      rsp_on_ff   <= rsp_on_in;
      rsp_note_ff <= rsp_note_in;
      rsp_vel_ff  <= rsp_vel_in;
   end

`ifndef SYNTHESIS
   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> (state_ff == S_IDLE) && !rsp_valid_ff)
      else $error("state not cleared by reset");

   a_note_off_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_on_ff) |-> (rsp_vel_ff == '0))
      else $error("note-off with nonzero velocity");

   a_vel_in_band: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN) |=>
         ((res_vel_ff >= min_vel_ff) && (res_vel_ff <= max_vel_ff)) ||
         ((res_vel_ff <= min_vel_ff) && (res_vel_ff >= max_vel_ff)))
      else $error("velocity outside min/max band");

   a_quot_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN) |-> (q_ff <= span_abs_ff))
      else $error("quotient exceeds velocity span");

   a_out_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && rsp_valid_ff && rsp_stall) |=>
         (state_ff == S_OUT) && $stable(rsp_note_ff))
      else $error("pending response overwritten");
`endif

endmodule
